FILE: src/track_center_motion_predictor_core_macros.svh
// Assertion macros shared by the track centre motion predictor RTL.
`ifndef TRACK_CENTER_MOTION_PREDICTOR_CORE_MACROS_SVH
`define TRACK_CENTER_MOTION_PREDICTOR_CORE_MACROS_SVH

// Check a property on every rising edge, ignored while reset is held.
`define TCMP_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define TCMP_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/tcmp_pkg.sv
// Types, constants and arithmetic helpers of the track centre motion predictor.
package tcmp_pkg;

    localparam int CENTER_W   = 13;
    localparam int PRED_W     = 15;
    localparam int CNT_W      = 3;
    localparam int HIST_DEPTH = 5;
    localparam int DELTA_W    = CENTER_W + 1;
    localparam int SUM_W      = 18;
    localparam int MAG_W      = SUM_W - 1;
    localparam int X_W        = SUM_W;
    localparam int RECIP_W    = 23;
    localparam int RECIP_SH   = 23;
    localparam int PROD_W     = X_W + RECIP_W;
    localparam int Q_W        = PROD_W - RECIP_SH;
    localparam int PCALC_W    = Q_W + 1;
    localparam int M_TDATA_W  = 64;
    localparam int M_FIELDS_W = 2 * CENTER_W + 2 * PRED_W + CNT_W;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HIST_DEPTH);

    typedef logic [CENTER_W-1:0]      center_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [X_W-1:0]           xnum_t;
    typedef logic [RECIP_W-1:0]       recip_t;
    typedef logic [PRED_W-1:0]        pred_t;

    // Weighted displacement sum; h0 is the newest centre, weights n-1 down to 1.
    function automatic sum_t weighted_sum(input center_t h0, input center_t h1,
                                          input center_t h2, input center_t h3,
                                          input center_t h4, input cnt_t n);
        sum_t d0;
        sum_t d1;
        sum_t d2;
        sum_t d3;
        sum_t s;
        d0 = SUM_W'($signed({1'b0, h0}) - $signed({1'b0, h1}));
        d1 = SUM_W'($signed({1'b0, h1}) - $signed({1'b0, h2}));
        d2 = SUM_W'($signed({1'b0, h2}) - $signed({1'b0, h3}));
        d3 = SUM_W'($signed({1'b0, h3}) - $signed({1'b0, h4}));
        case (n)
            3'd2:    s = d0;
            3'd3:    s = (d0 <<< 1) + d1;
            3'd4:    s = (d0 <<< 1) + d0 + (d1 <<< 1) + d2;
            3'd5:    s = (d0 <<< 2) + (d1 <<< 1) + d1 + (d2 <<< 1) + d3;
            default: s = '0;
        endcase
        return s;
    endfunction

    // Divisor of the weighted average for n stored centres.
    function automatic xnum_t divisor(input cnt_t n);
        xnum_t d;
        case (n)
            3'd3:    d = X_W'(3);
            3'd4:    d = X_W'(6);
            3'd5:    d = X_W'(10);
            default: d = X_W'(1);
        endcase
        return d;
    endfunction

    // ceil(2^23 / (2 * divisor)); exact floor division for numerators below 2^18.
    function automatic recip_t recip(input cnt_t n);
        recip_t m;
        case (n)
            3'd3:    m = RECIP_W'(1398102);
            3'd4:    m = RECIP_W'(699051);
            3'd5:    m = RECIP_W'(419431);
            default: m = RECIP_W'(4194304);
        endcase
        return m;
    endfunction

endpackage

FILE: src/track_center_motion_predictor_core.sv
// Track centre motion predictor: box centre, five-entry history and weighted prediction.
// Stages: history, sum and divide, from the accepting edge to result valid.
// Throughput: one item per cycle; the single shared history register set is updated
// once per accepted item, and a stalled result stalls the input through the pipe.
// Reset (aresetn low, synchronous): empties the pipeline and clears the stored count;
// the history entries themselves are not cleared and are read only once written.
`include "track_center_motion_predictor_core_macros.svh"

module track_center_motion_predictor_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // box_left, box_top, box_width, box_height (COORD_BITS each), zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // command: 0 append, 1 start new track
    input  logic                                  s_tuser,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // center_x[12:0], center_y[25:13], predicted_x[40:26],
    // predicted_y[55:41], history_count[58:56], zero padded
    output logic [tcmp_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready
);

    localparam int DEPTH     = tcmp_pkg::HIST_DEPTH;

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic [COORD_BITS:0]   cx_full;
    logic [COORD_BITS:0]   cy_full;
    tcmp_pkg::center_t     cx_next;
    tcmp_pkg::center_t     cy_next;

    assign box_left   = s_tdata[COORD_BITS-1:0];
    assign box_top    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign box_width  = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign box_height = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    // Floor the centre: left edge plus half the width, kept to 13 bits.
    assign cx_full = {1'b0, box_left} + {2'b00, box_width[COORD_BITS-1:1]};
    assign cy_full = {1'b0, box_top}  + {2'b00, box_height[COORD_BITS-1:1]};
    assign cx_next = tcmp_pkg::CENTER_W'(cx_full);
    assign cy_next = tcmp_pkg::CENTER_W'(cy_full);

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage loads when the one after it frees
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic m_valid_reg;
    logic m_free;
    logic b_free;
    logic a_free;
    logic s_accept;

    assign m_free   = !m_valid_reg || m_tready;
    assign b_free   = !b_valid_reg || m_free;
    assign a_free   = !a_valid_reg || b_free;
    assign s_tready = a_free;
    assign s_accept = s_tvalid && a_free;
    assign m_tvalid = m_valid_reg;

    // ------------------------------------------------------------------
    // Stage A: history shift register and stored count
    // ------------------------------------------------------------------
    tcmp_pkg::center_t hist_x_reg [DEPTH];
    tcmp_pkg::center_t hist_y_reg [DEPTH];
    tcmp_pkg::cnt_t    cnt_reg;
    tcmp_pkg::cnt_t    cnt_next;

    // A new track, or an append to an empty one, restarts at one centre.
    always_comb begin
        if (s_tuser || cnt_reg == '0) begin
            cnt_next = tcmp_pkg::CNT_ONE;
        end else if (cnt_reg >= tcmp_pkg::CNT_FULL) begin
            cnt_next = tcmp_pkg::CNT_FULL;
        end else begin
            cnt_next = cnt_reg + tcmp_pkg::CNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            if (a_free) begin
                a_valid_reg <= s_tvalid;
            end
            if (s_accept) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Shift the oldest centre out and push the new one at the head.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hist_x_reg[0] <= cx_next;
            hist_y_reg[0] <= cy_next;
            for (int i = 1; i < DEPTH; i++) begin
                hist_x_reg[i] <= hist_x_reg[i-1];
                hist_y_reg[i] <= hist_y_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: weighted displacement sum, magnitude and rounding offset
    // ------------------------------------------------------------------
    tcmp_pkg::sum_t    sum_x;
    tcmp_pkg::sum_t    sum_y;
    tcmp_pkg::xnum_t   div_d;
    tcmp_pkg::xnum_t   num_x_next;
    tcmp_pkg::xnum_t   num_y_next;
    tcmp_pkg::xnum_t   num_x_reg;
    tcmp_pkg::xnum_t   num_y_reg;
    logic              neg_x_reg;
    logic              neg_y_reg;
    tcmp_pkg::center_t b_cx_reg;
    tcmp_pkg::center_t b_cy_reg;
    tcmp_pkg::cnt_t    b_cnt_reg;
    logic [tcmp_pkg::MAG_W-1:0] mag_x;
    logic [tcmp_pkg::MAG_W-1:0] mag_y;

    assign sum_x = tcmp_pkg::weighted_sum(hist_x_reg[0], hist_x_reg[1], hist_x_reg[2],
                                          hist_x_reg[3], hist_x_reg[4], cnt_reg);
    assign sum_y = tcmp_pkg::weighted_sum(hist_y_reg[0], hist_y_reg[1], hist_y_reg[2],
                                          hist_y_reg[3], hist_y_reg[4], cnt_reg);
    assign div_d = tcmp_pkg::divisor(cnt_reg);

    // Round half away from zero: floor((2|s| + d) / 2d), sign restored later.
    assign mag_x = tcmp_pkg::MAG_W'(sum_x[tcmp_pkg::SUM_W-1] ? -sum_x : sum_x);
    assign mag_y = tcmp_pkg::MAG_W'(sum_y[tcmp_pkg::SUM_W-1] ? -sum_y : sum_y);
    assign num_x_next = {mag_x, 1'b0} + div_d;
    assign num_y_next = {mag_y, 1'b0} + div_d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_free && a_valid_reg) begin
            num_x_reg <= num_x_next;
            num_y_reg <= num_y_next;
            neg_x_reg <= sum_x[tcmp_pkg::SUM_W-1];
            neg_y_reg <= sum_y[tcmp_pkg::SUM_W-1];
            b_cx_reg  <= hist_x_reg[0];
            b_cy_reg  <= hist_y_reg[0];
            b_cnt_reg <= cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: reciprocal multiply, sign, add newest centre, result register
    // ------------------------------------------------------------------
    tcmp_pkg::recip_t                         recip_m;
    logic [tcmp_pkg::PROD_W-1:0]              prod_x;
    logic [tcmp_pkg::PROD_W-1:0]              prod_y;
    logic [tcmp_pkg::Q_W-1:0]                 q_x;
    logic [tcmp_pkg::Q_W-1:0]                 q_y;
    logic signed [tcmp_pkg::PCALC_W-1:0]      sq_x;
    logic signed [tcmp_pkg::PCALC_W-1:0]      sq_y;
    logic signed [tcmp_pkg::PCALC_W-1:0]      px_full;
    logic signed [tcmp_pkg::PCALC_W-1:0]      py_full;
    tcmp_pkg::pred_t                          px_next;
    tcmp_pkg::pred_t                          py_next;
    tcmp_pkg::center_t                        m_cx_reg;
    tcmp_pkg::center_t                        m_cy_reg;
    tcmp_pkg::pred_t                          m_px_reg;
    tcmp_pkg::pred_t                          m_py_reg;
    tcmp_pkg::cnt_t                           m_cnt_reg;

    assign recip_m = tcmp_pkg::recip(b_cnt_reg);
    assign prod_x  = {{tcmp_pkg::RECIP_W{1'b0}}, num_x_reg} *
                     {{tcmp_pkg::X_W{1'b0}}, recip_m};
    assign prod_y  = {{tcmp_pkg::RECIP_W{1'b0}}, num_y_reg} *
                     {{tcmp_pkg::X_W{1'b0}}, recip_m};
    assign q_x     = prod_x[tcmp_pkg::PROD_W-1:tcmp_pkg::RECIP_SH];
    assign q_y     = prod_y[tcmp_pkg::PROD_W-1:tcmp_pkg::RECIP_SH];

    assign sq_x    = neg_x_reg ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
    assign sq_y    = neg_y_reg ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
    assign px_full = $signed(tcmp_pkg::PCALC_W'(b_cx_reg)) + sq_x;
    assign py_full = $signed(tcmp_pkg::PCALC_W'(b_cy_reg)) + sq_y;
    assign px_next = px_full[tcmp_pkg::PRED_W-1:0];
    assign py_next = py_full[tcmp_pkg::PRED_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_free) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    // Hold the result until taken; load the next one as soon as the slot frees.
    always_ff @(posedge aclk) begin
        if (m_free && b_valid_reg) begin
            m_cx_reg  <= b_cx_reg;
            m_cy_reg  <= b_cy_reg;
            m_px_reg  <= px_next;
            m_py_reg  <= py_next;
            m_cnt_reg <= b_cnt_reg;
        end
    end

    assign m_tdata = {{(tcmp_pkg::M_TDATA_W - tcmp_pkg::M_FIELDS_W){1'b0}},
                      m_cnt_reg, m_py_reg, m_px_reg, m_cy_reg, m_cx_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TCMP_ASSERT(a_cnt_range, aclk, aresetn, (cnt_reg <= tcmp_pkg::CNT_FULL),
                 "stored count above five")
    `TCMP_ASSERT(a_new_track, aclk, aresetn,
                 (s_accept && s_tuser) |=> (cnt_reg == tcmp_pkg::CNT_ONE),
                 "new track did not restart the count")
    `TCMP_ASSERT(a_b_to_m, aclk, aresetn, (b_valid_reg && m_free) |=> m_valid_reg,
                 "item lost between sum stage and result")
    `TCMP_ASSERT(a_single_pred, aclk, aresetn,
                 (m_valid_reg && m_cnt_reg == tcmp_pkg::CNT_ONE) |->
                 (m_px_reg == tcmp_pkg::PRED_W'(m_cx_reg) &&
                  m_py_reg == tcmp_pkg::PRED_W'(m_cy_reg)),
                 "single centre prediction differs from centre")
    `TCMP_ASSERT_ALWAYS(a_empty_ready, aclk, (!a_valid_reg) |-> s_tready,
                        "input stalled with empty history stage")

endmodule

FILE: sim/track_center_motion_predictor_core_checker.sv
`timescale 1ns / 100ps
// Checker of the track centre motion predictor: rebuilds every result and compares it.
module track_center_motion_predictor_core_checker #(
    parameter int COORD_BITS = 12,
    parameter int S_TDATA_W  = ((4*COORD_BITS+7)/8)*8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [S_TDATA_W-1:0]           s_tdata,
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tcmp_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    output int                             fail_count,
    output int                             outstanding,
    output int                             results_seen,
    output int                             deep_results
);

    localparam int CENTER_W = tcmp_pkg::CENTER_W;
    localparam int PRED_W   = tcmp_pkg::PRED_W;
    localparam int CNT_W    = tcmp_pkg::CNT_W;
    localparam int DEPTH    = tcmp_pkg::HIST_DEPTH;
    localparam int CY_LSB   = CENTER_W;
    localparam int PX_LSB   = 2 * CENTER_W;
    localparam int PY_LSB   = 2 * CENTER_W + PRED_W;
    localparam int CNT_LSB  = 2 * CENTER_W + 2 * PRED_W;
    localparam int SHOWN    = 40;

    typedef struct packed {
        tcmp_pkg::center_t cx;
        tcmp_pkg::center_t cy;
        tcmp_pkg::pred_t   px;
        tcmp_pkg::pred_t   py;
        tcmp_pkg::cnt_t    n;
    } centre_result_t;

    tcmp_pkg::center_t trail_x [DEPTH];
    tcmp_pkg::center_t trail_y [DEPTH];
    int                trail_len = 0;
    centre_result_t    due_q [$];
    int                mismatches = 0;
    int                seen = 0;
    int                deep = 0;
    int                due_r = 0;

    assign fail_count   = mismatches;
    assign outstanding  = due_r;
    assign results_seen = seen;
    assign deep_results = deep;

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= SHOWN)
            $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    // Newest centre plus the weighted mean of up to four displacements, rounded
    // half away from zero.
    function automatic tcmp_pkg::pred_t forecast(input tcmp_pkg::center_t h0,
                                                 input tcmp_pkg::center_t h1,
                                                 input tcmp_pkg::center_t h2,
                                                 input tcmp_pkg::center_t h3,
                                                 input tcmp_pkg::center_t h4,
                                                 input int n);
        int hv [DEPTH];
        int acc;
        int div;
        int mag;
        int q;
        int k;
        hv[0] = h0;
        hv[1] = h1;
        hv[2] = h2;
        hv[3] = h3;
        hv[4] = h4;
        acc = 0;
        for (k = 0; k + 1 < n; k++)
            acc += (hv[k] - hv[k+1]) * (n - 1 - k);
        case (n)
            3:       div = 3;
            4:       div = 6;
            5:       div = 10;
            default: div = 1;
        endcase
        mag = (acc < 0) ? -acc : acc;
        q = (2 * mag + div) / (2 * div);
        if (acc < 0)
            q = -q;
        return tcmp_pkg::pred_t'(hv[0] + q);
    endfunction

    always @(posedge aclk) begin : watch
        centre_result_t want;
        centre_result_t got;
        int             cx;
        int             cy;
        int             i;
        if (!aresetn) begin
            trail_len = 0;
            due_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.cx = m_tdata[CENTER_W-1:0];
                got.cy = m_tdata[CY_LSB +: CENTER_W];
                got.px = m_tdata[PX_LSB +: PRED_W];
                got.py = m_tdata[PY_LSB +: PRED_W];
                got.n  = m_tdata[CNT_LSB +: CNT_W];
                seen++;
                if (got.n == tcmp_pkg::CNT_FULL)
                    deep++;
                if (due_q.size() == 0) begin
                    report("unexpected item, center_x", got.cx, -1);
                end else begin
                    want = due_q.pop_front();
                    if (got.cx !== want.cx)
                        report("center_x", got.cx, want.cx);
                    if (got.cy !== want.cy)
                        report("center_y", got.cy, want.cy);
                    if (got.px !== want.px)
                        report("predicted_x", int'($signed(got.px)), int'($signed(want.px)));
                    if (got.py !== want.py)
                        report("predicted_y", int'($signed(got.py)), int'($signed(want.py)));
                    if (got.n !== want.n)
                        report("history_count", got.n, want.n);
                    if (m_tdata[tcmp_pkg::M_TDATA_W-1:tcmp_pkg::M_FIELDS_W] !== '0)
                        report("tdata padding",
                               int'(m_tdata[tcmp_pkg::M_TDATA_W-1:tcmp_pkg::M_FIELDS_W]), 0);
                end
            end
            if (s_tvalid && s_tready) begin
                // floor the centre, restart on a new track, shift the history
                cx = s_tdata[0 +: COORD_BITS] + (s_tdata[2*COORD_BITS +: COORD_BITS] >> 1);
                cy = s_tdata[COORD_BITS +: COORD_BITS]
                   + (s_tdata[3*COORD_BITS +: COORD_BITS] >> 1);
                if (s_tuser)
                    trail_len = 0;
                for (i = DEPTH - 1; i > 0; i--) begin
                    trail_x[i] = trail_x[i-1];
                    trail_y[i] = trail_y[i-1];
                end
                trail_x[0] = tcmp_pkg::center_t'(cx);
                trail_y[0] = tcmp_pkg::center_t'(cy);
                if (trail_len < DEPTH)
                    trail_len++;
                want.cx = trail_x[0];
                want.cy = trail_y[0];
                want.px = forecast(trail_x[0], trail_x[1], trail_x[2], trail_x[3],
                                   trail_x[4], trail_len);
                want.py = forecast(trail_y[0], trail_y[1], trail_y[2], trail_y[3],
                                   trail_y[4], trail_len);
                want.n  = tcmp_pkg::cnt_t'(trail_len);
                due_q.insert(due_q.size(), want);
            end
        end
        due_r <= due_q.size();
    end

endmodule

FILE: sim/track_center_motion_predictor_core_test.sv
`timescale 1ns / 100ps
// Testbench top of the track centre motion predictor: stimulus, handshake idling and verdict.
module track_center_motion_predictor_core_test;

    localparam int   COORD_BITS    = 12;
    localparam int   S_TDATA_W     = ((4*COORD_BITS+7)/8)*8;
    localparam int   COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int   RANDOM_ITEMS  = 1230;
    localparam int   TAIL_CYCLES   = 12;
    localparam int   LIMIT_CYCLES  = 200000;
    localparam logic CMD_APPEND    = 1'b0;
    localparam logic CMD_NEW_TRACK = 1'b1;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    // box_left, box_top, box_width, box_height from bit 0 up
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // command
    logic                 s_tuser  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // center_x, center_y, predicted_x, predicted_y, history_count from bit 0 up
    logic [tcmp_pkg::M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    int send_idle_pct = 27;
    int recv_idle_pct = 84;
    int items_sent    = 0;
    int tracks_opened = 0;
    int cycles        = 0;
    int fail_count;
    int outstanding;
    int results_seen;
    int deep_results;

    always #2 aclk = ~aclk;

    track_center_motion_predictor_core #(
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    track_center_motion_predictor_core_checker #(
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .deep_results (deep_results)
    );

    // Watchdog: abandon a run that hangs.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d items outstanding", cycles, outstanding);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: stall at the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one item, idling first at the sender's rate, and hold it until taken.
    // Valid stays high on return so back-to-back items need no extra edge.
    task automatic drive_box(input logic cmd, input int left, input int top,
                             input int wid, input int hgt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({COORD_BITS'(hgt), COORD_BITS'(wid),
                                COORD_BITS'(top), COORD_BITS'(left)});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        if (cmd == CMD_NEW_TRACK)
            tracks_opened++;
    endtask

    function automatic int bounded(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // Random tracks: mostly smooth motion with jitter, some with wild boxes,
    // some that carry on the previous track, and lone items as noise.
    task automatic run_tracks(input int quota);
        int goal;
        int len;
        int k;
        int left;
        int top;
        int wid;
        int hgt;
        int vx;
        int vy;
        int style;
        logic cmd;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            style = $urandom_range(9);
            len   = ($urandom_range(7) == 0) ? $urandom_range(16, 10) : $urandom_range(8, 1);
            left  = $urandom_range(COORD_MAX);
            top   = $urandom_range(COORD_MAX);
            wid   = $urandom_range(COORD_MAX >> 2);
            hgt   = $urandom_range(COORD_MAX >> 2);
            vx    = int'($urandom_range(160)) - 80;
            vy    = int'($urandom_range(160)) - 80;
            if (style == 0) begin
                drive_box(logic'($urandom_range(1)), $urandom_range(COORD_MAX),
                          $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                          $urandom_range(COORD_MAX));
            end else begin
                for (k = 0; k < len; k++) begin
                    if (style <= 2) begin
                        left = $urandom_range(COORD_MAX);
                        top  = $urandom_range(COORD_MAX);
                        wid  = $urandom_range(COORD_MAX);
                        hgt  = $urandom_range(COORD_MAX);
                    end else if (k != 0) begin
                        left = bounded(left + vx + int'($urandom_range(6)) - 3);
                        top  = bounded(top + vy + int'($urandom_range(6)) - 3);
                        wid  = bounded(wid + int'($urandom_range(8)) - 4);
                        hgt  = bounded(hgt + int'($urandom_range(8)) - 4);
                    end
                    // a track that opens with an append continues the one before
                    cmd = (k == 0 && style != 3) ? CMD_NEW_TRACK : CMD_APPEND;
                    drive_box(cmd, left, top, wid, hgt);
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Append on an empty track: behaves as a new track.
        drive_box(CMD_APPEND, 0, 0, 0, 0);
        // Long track swinging between the extremes: only five centres kept,
        // large displacements of both signs.
        drive_box(CMD_APPEND, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        drive_box(CMD_APPEND, 0, 0, 0, 0);
        drive_box(CMD_APPEND, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        drive_box(CMD_APPEND, 0, 0, 0, 0);
        drive_box(CMD_APPEND, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        drive_box(CMD_APPEND, 0, COORD_MAX, COORD_MAX, 0);
        // Single centre: the prediction is the centre itself.
        drive_box(CMD_NEW_TRACK, COORD_MAX, 0, COORD_MAX, 0);
        // Odd sizes: the centre floors.
        drive_box(CMD_NEW_TRACK, 10, 20, 7, 9);
        // Four centres, weighted sum of +-3 over six: the half rounds away from zero.
        drive_box(CMD_NEW_TRACK, 0, 1, 0, 0);
        drive_box(CMD_APPEND, 0, 1, 0, 0);
        drive_box(CMD_APPEND, 0, 1, 0, 0);
        drive_box(CMD_APPEND, 1, 0, 0, 0);
        // Five centres, weighted sum of +-5 over ten: the half rounds away from
        // zero and the vertical prediction goes negative.
        drive_box(CMD_NEW_TRACK, 0, 2, 0, 0);
        drive_box(CMD_APPEND, 1, 1, 0, 0);
        drive_box(CMD_APPEND, 1, 1, 0, 0);
        drive_box(CMD_APPEND, 1, 1, 0, 0);
        drive_box(CMD_APPEND, 2, 0, 0, 0);

        // Sender light, receiver heavy; then the other way round; then flat out.
        run_tracks(RANDOM_ITEMS / 3);
        send_idle_pct = 84;
        recv_idle_pct = 27;
        run_tracks(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_tracks(RANDOM_ITEMS / 3);

        // Drop valid, let the checker catch up, drain, then allow the pipe to settle.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("stimulus: %0d boxes over %0d new tracks, idle phases 27/84, 84/27, 0/0",
                 items_sent, tracks_opened);
        $display("checked %0d results, %0d of them on a full five-centre history",
                 results_seen, deep_results);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/tcmp_pkg.sv
src/track_center_motion_predictor_core.sv
sim/track_center_motion_predictor_core_checker.sv
sim/track_center_motion_predictor_core_test.sv
